// ===== rtl/sdbi_pkg.sv =====
// ----------------------------------------------------------------------------
// sdbi_pkg
// Shared types and constants for the signed divide-by-invariant block.
// ----------------------------------------------------------------------------
`default_nettype none

package sdbi_pkg;

  // width of the dividend, divisor and quotient ports
  localparam int unsigned IO_WIDTH = 32;

  // divisor setup sequencer
  typedef enum logic [2:0] {
    DRV_IDLE,
    DRV_PREP,
    DRV_LEN,
    DRV_DIV,
    DRV_REDUCE
  } drv_state_t;

endpackage

`default_nettype wire

// ===== rtl/signed_divide_by_invariant.sv =====
// ----------------------------------------------------------------------------
// signed_divide_by_invariant
// Signed division of a dividend stream by a programmable divisor, truncating
// toward zero, using a reciprocal multiply derived when the divisor is set.
// ----------------------------------------------------------------------------
// Usage:
//   Divisor channel: divisor_valid/divisor_ready with the divisor value. A
//   write starts a setup sequence that derives the reciprocal multiplier and
//   shift; busy is high and divisor_ready low until it ends. Setup scans the
//   bit length len of |d|-1, then runs the one-bit-per-cycle long division
//   and up to len multiplier reductions; a power-of-two divisor finishes
//   after the bit-length scan, a zero divisor in the prepare step.
//   Dividend channel: a dividend is taken at each edge where start is high
//   and busy is low, one per cycle.
//   Results: quotient and divide_by_zero are shown for one cycle with done
//   high, after the input register, multiply, add and shift/sign-fix
//   stages. The receiver takes every result; there is no back-pressure.
//   Zero divisor: quotient is 0 and divide_by_zero is 1.
//   Reset: settings for divisor 1, pipeline empty, block idle.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_divide_by_invariant #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               divisor_valid,
  output logic                              divisor_ready,
  input  wire  [sdbi_pkg::IO_WIDTH-1:0]     divisor,
  input  wire                               start,
  output logic                              busy,
  input  wire  [sdbi_pkg::IO_WIDTH-1:0]     dividend,
  output logic                              done,
  output logic [sdbi_pkg::IO_WIDTH-1:0]     quotient,
  output logic                              divide_by_zero
);

  localparam int unsigned W     = DATA_WIDTH;
  localparam int unsigned LEN_W = $clog2(DATA_WIDTH);
  localparam int unsigned CNT_W = $clog2(2 * DATA_WIDTH);

  // --------------------------------------------------------------------------
  // Committed settings
  // --------------------------------------------------------------------------
  logic                 set_neg;
  logic                 set_zero;
  logic                 set_pow2;
  logic [LEN_W-1:0]     set_exp;
  logic [LEN_W-1:0]     set_shift;
  logic                 set_big;
  logic signed [W:0]    set_mult;

  // --------------------------------------------------------------------------
  // Setup sequencer
  // --------------------------------------------------------------------------
  sdbi_pkg::drv_state_t state, state_next;

  logic [W-1:0]         drv_mag;
  logic                 drv_neg;
  logic                 drv_pow2;
  logic [W-1:0]         drv_t;
  logic [LEN_W-1:0]     drv_len;
  logic [CNT_W-1:0]     drv_cnt;
  logic [W-1:0]         rem_lo;
  logic [W-1:0]         rem_hi;
  logic [W:0]           quo_lo;
  logic [W:0]           quo_hi;
  logic [LEN_W-1:0]     drv_sh;

  logic                 cfg_fire;
  logic signed [W-1:0]  cfg_d;
  logic [CNT_W:0]       pos_lo;
  logic [CNT_W:0]       pos_hi;
  logic                 bit_lo;
  logic                 bit_hi;
  logic [W:0]           try_lo;
  logic [W:0]           try_hi;
  logic                 fit_lo;
  logic                 fit_hi;
  logic                 reduce_go;

  assign cfg_fire = divisor_valid && divisor_ready;
  assign cfg_d    = divisor[W-1:0];

  // numerator bit positions: 2^(W+len) for both, plus 2^(len+1) for the upper bound
  assign pos_lo = (CNT_W+1)'(W) + (CNT_W+1)'(drv_len);
  assign pos_hi = (CNT_W+1)'(drv_len) + (CNT_W+1)'(1);
  assign bit_lo = ({1'b0, drv_cnt} == pos_lo);
  assign bit_hi = bit_lo || ({1'b0, drv_cnt} == pos_hi);

  // one restoring division step for each bound
  assign try_lo = {rem_lo, bit_lo};
  assign try_hi = {rem_hi, bit_hi};
  assign fit_lo = (try_lo >= {1'b0, drv_mag});
  assign fit_hi = (try_hi >= {1'b0, drv_mag});

  assign reduce_go = (quo_lo[W:1] < quo_hi[W:1]) && (drv_sh != '0);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sdbi_pkg::DRV_IDLE: begin
        if (cfg_fire) state_next = sdbi_pkg::DRV_PREP;
      end
      sdbi_pkg::DRV_PREP: begin
        if (drv_mag == '0) state_next = sdbi_pkg::DRV_IDLE;
        else state_next = sdbi_pkg::DRV_LEN;
      end
      sdbi_pkg::DRV_LEN: begin
        if (drv_t == '0) begin
          if (drv_pow2) state_next = sdbi_pkg::DRV_IDLE;
          else state_next = sdbi_pkg::DRV_DIV;
        end
      end
      sdbi_pkg::DRV_DIV: begin
        if (drv_cnt == '0) state_next = sdbi_pkg::DRV_REDUCE;
      end
      sdbi_pkg::DRV_REDUCE: begin
        if (!reduce_go) state_next = sdbi_pkg::DRV_IDLE;
      end
      default: state_next = sdbi_pkg::DRV_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    case (state)
      sdbi_pkg::DRV_IDLE: begin
        busy          = 1'b0;
        divisor_ready = 1'b1;
      end
      default: begin
        busy          = 1'b1;
        divisor_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= sdbi_pkg::DRV_IDLE;
    else state <= state_next;
  end

  // setup working registers
  always_ff @(posedge clk) begin
    case (state)
      sdbi_pkg::DRV_IDLE: begin
        if (cfg_fire) begin
          drv_neg <= cfg_d[W-1];
          drv_mag <= cfg_d[W-1] ? W'(-cfg_d) : W'(cfg_d);
        end
      end
      sdbi_pkg::DRV_PREP: begin
        drv_pow2 <= ((drv_mag & (drv_mag - W'(1))) == '0);
        drv_t    <= drv_mag - W'(1);
        drv_len  <= '0;
      end
      sdbi_pkg::DRV_LEN: begin
        if (drv_t != '0) begin
          drv_t   <= drv_t >> 1;
          drv_len <= drv_len + LEN_W'(1);
        end else begin
          drv_cnt <= CNT_W'(2 * W - 1);
          rem_lo  <= '0;
          rem_hi  <= '0;
          quo_lo  <= '0;
          quo_hi  <= '0;
        end
      end
      sdbi_pkg::DRV_DIV: begin
        rem_lo  <= fit_lo ? W'(try_lo - {1'b0, drv_mag}) : try_lo[W-1:0];
        rem_hi  <= fit_hi ? W'(try_hi - {1'b0, drv_mag}) : try_hi[W-1:0];
        quo_lo  <= {quo_lo[W-1:0], fit_lo};
        quo_hi  <= {quo_hi[W-1:0], fit_hi};
        drv_cnt <= drv_cnt - CNT_W'(1);
        drv_sh  <= drv_len;
      end
      sdbi_pkg::DRV_REDUCE: begin
        if (reduce_go) begin
          quo_lo <= quo_lo >> 1;
          quo_hi <= quo_hi >> 1;
          drv_sh <= drv_sh - LEN_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // commit settings at the end of setup
  always_ff @(posedge clk) begin
    if (rst) begin
      set_neg   <= 1'b0;
      set_zero  <= 1'b0;
      set_pow2  <= 1'b1;
      set_exp   <= '0;
      set_shift <= '0;
      set_big   <= 1'b0;
      set_mult  <= '0;
    end else begin
      case (state)
        sdbi_pkg::DRV_PREP: begin
          if (drv_mag == '0) begin
            set_neg   <= drv_neg;
            set_zero  <= 1'b1;
            set_pow2  <= 1'b0;
            set_exp   <= '0;
            set_shift <= '0;
            set_big   <= 1'b0;
            set_mult  <= '0;
          end
        end
        sdbi_pkg::DRV_LEN: begin
          if (drv_t == '0 && drv_pow2) begin
            set_neg   <= drv_neg;
            set_zero  <= 1'b0;
            set_pow2  <= 1'b1;
            set_exp   <= drv_len;
            set_shift <= '0;
          end
        end
        sdbi_pkg::DRV_REDUCE: begin
          if (!reduce_go) begin
            set_neg   <= drv_neg;
            set_zero  <= 1'b0;
            set_pow2  <= 1'b0;
            set_exp   <= '0;
            set_shift <= drv_sh;
            // a multiplier of 2^(W-1) or more is used as itself minus 2^W
            set_big   <= (quo_hi >= (W+1)'(1) << (W - 1));
            set_mult  <= (quo_hi >= (W+1)'(1) << (W - 1))
                         ? $signed(quo_hi ^ ((W+1)'(1) << W))
                         : $signed(quo_hi);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Dividend pipeline
  // --------------------------------------------------------------------------
  logic                 s0_valid;
  logic signed [W-1:0]  s0_x;

  logic                 s1_valid;
  logic signed [W-1:0]  s1_x;
  logic signed [2*W:0]  s1_prod;
  logic signed [W:0]    s1_pq;

  logic                 s2_valid;
  logic                 s2_xneg;
  logic signed [W+1:0]  s2_t;
  logic signed [W:0]    s2_pq;

  logic signed [W:0]    pow_bias;
  logic signed [W:0]    pow_sum;
  logic signed [W:0]    mul_high;
  logic signed [W+1:0]  mul_t;
  logic signed [W+1:0]  mul_q;
  logic signed [W+1:0]  sel_q;
  logic signed [W+1:0]  fix_q;
  logic signed [W-1:0]  out_q;

  // take the dividend beat
  always_ff @(posedge clk) begin
    if (rst) s0_valid <= 1'b0;
    else s0_valid <= start && !busy;
  end

  always_ff @(posedge clk) begin
    s0_x <= dividend[W-1:0];
  end

  // stage 1: multiply, and bias-and-shift for power-of-two divisors
  assign pow_bias = s0_x[W-1] ? $signed(~({(W+1){1'b1}} << set_exp)) : '0;
  assign pow_sum  = (W+1)'(s0_x) + pow_bias;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else s1_valid <= s0_valid;
  end

  always_ff @(posedge clk) begin
    s1_x    <= s0_x;
    s1_prod <= set_mult * s0_x;
    s1_pq   <= pow_sum >>> set_exp;
  end

  // stage 2: take the high half, add the dividend back for large multipliers
  assign mul_high = s1_prod[2*W:W];
  assign mul_t    = set_big ? (W+2)'(s1_x) + (W+2)'(mul_high) : (W+2)'(mul_high);

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else s2_valid <= s1_valid;
  end

  always_ff @(posedge clk) begin
    s2_xneg <= s1_x[W-1];
    s2_t    <= mul_t;
    s2_pq   <= s1_pq;
  end

  // stage 3: post-shift, round toward zero, apply divisor sign
  assign mul_q = (s2_t >>> set_shift) + $signed((W+2)'(s2_xneg));
  assign sel_q = set_pow2 ? (W+2)'(s2_pq) : mul_q;
  assign fix_q = set_neg ? -sel_q : sel_q;
  assign out_q = set_zero ? '0 : fix_q[W-1:0];

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= s2_valid;
  end

  always_ff @(posedge clk) begin
    quotient       <= sdbi_pkg::IO_WIDTH'(out_q);
    divide_by_zero <= set_zero;
  end

endmodule

`default_nettype wire

// ===== test/tb_signed_divide_by_invariant.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_divide_by_invariant
// Self-checking bench for the divide-by-invariant block. A scoreboard class
// recomputes the magic multiplier and post-shift each time the divisor is
// written. It predicts every quotient and divide-by-zero flag, and checks
// them in order against the done strobe. The stimulus starts with directed
// extremes (INT_MIN over -1, zero and most negative divisors), then runs
// random divisor segments under three sender idle rates.
// ----------------------------------------------------------------------------

module tb_signed_divide_by_invariant;

  localparam int unsigned IO_WIDTH    = sdbi_pkg::IO_WIDTH;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [IO_WIDTH-1:0] quotient;
    logic                divide_by_zero;
  } quot_beat_t;

  // Predicts quotients for the current divisor and holds them until checked
  class quotient_scoreboard;
    quot_beat_t  expected_quotients[$];
    int unsigned errors;
    logic        div_neg;
    logic        div_zero;
    logic        div_pow2;
    logic [4:0]  pow_exp;
    logic [32:0] magic;
    logic [4:0]  post_sh;

    function new();
      errors = 0;
      load_divisor(32'd1);
    endfunction

    function int unsigned pending();
      return expected_quotients.size();
    endfunction

    // Derive negate flag, exponent, multiplier and shift for a new divisor
    function void load_divisor(logic [IO_WIDTH-1:0] d);
      longint unsigned mag, t, num, lo, hi;
      int unsigned     len, k, sh;
      div_neg  = d[IO_WIDTH-1];
      mag      = div_neg ? 64'd0 - {{32{d[31]}}, d} : {32'd0, d};
      div_zero = (mag == 0);
      len      = 0;
      k        = 0;
      if (div_zero) begin
        div_pow2 = 1'b0;
        pow_exp  = '0;
        magic    = '0;
        post_sh  = '0;
        return;
      end
      div_pow2 = ((mag & (mag - 1)) == 0);
      t = mag;
      while (t[0] == 1'b0) begin
        t = t >> 1;
        k++;
      end
      pow_exp = div_pow2 ? k[4:0] : 5'd0;
      t = mag - 1;
      while (t != 0) begin
        t = t >> 1;
        len++;
      end
      sh  = len;
      num = 64'd1 << (IO_WIDTH + len);
      lo  = num / mag;
      hi  = (num + (64'd1 << (len + 1))) / mag;
      // shrink the multiplier while the rounding interval allows
      while ((lo >> 1) < (hi >> 1) && sh > 0) begin
        lo = lo >> 1;
        hi = hi >> 1;
        sh--;
      end
      magic   = hi[32:0];
      post_sh = sh[4:0];
    endfunction

    // Compute the expected beat for one accepted dividend
    function void note_dividend(logic [IO_WIDTH-1:0] x_in);
      longint     x, bias, m, high, t, q;
      logic       big;
      quot_beat_t want;
      x = {{32{x_in[31]}}, x_in};
      if (div_zero) begin
        want.quotient       = '0;
        want.divide_by_zero = 1'b1;
      end else begin
        if (div_pow2) begin
          bias = x_in[31] ? (64'sd1 <<< pow_exp) - 64'sd1 : 64'sd0;
          q    = (x + bias) >>> pow_exp;
        end else begin
          big = (magic >= 33'h0_8000_0000);
          m   = {31'd0, magic};
          if (big)
            m = m - (64'sd1 <<< 32);
          high = (m * x) >>> 32;
          t    = big ? x + high : high;
          q    = (t >>> post_sh) + (x_in[31] ? 64'sd1 : 64'sd0);
        end
        if (div_neg)
          q = -q;
        want.quotient       = q[31:0];
        want.divide_by_zero = 1'b0;
      end
      expected_quotients.push_back(want);
    endfunction

    // Compare one result beat against the oldest prediction
    function void check_quotient(logic [IO_WIDTH-1:0] q, logic dz);
      quot_beat_t want;
      if (expected_quotients.size() == 0) begin
        $display("%0t: unexpected result beat: quotient %h divide_by_zero %b",
                 $time, q, dz);
        errors++;
        return;
      end
      want = expected_quotients.pop_front();
      if (q !== want.quotient) begin
        $display("%0t: quotient mismatch: expected %h actual %h",
                 $time, want.quotient, q);
        errors++;
      end
      if (dz !== want.divide_by_zero) begin
        $display("%0t: divide_by_zero mismatch: expected %b actual %b",
                 $time, want.divide_by_zero, dz);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                divisor_valid;
  logic                divisor_ready;
  logic [IO_WIDTH-1:0] divisor;
  logic                start;
  logic                busy;
  logic [IO_WIDTH-1:0] dividend;
  logic                done;
  logic [IO_WIDTH-1:0] quotient;
  logic                divide_by_zero;

  quotient_scoreboard quot_board = new();
  int unsigned        sender_idle_pct;
  int unsigned        cycle_count;

  signed_divide_by_invariant dut (
    .clk            (clk),
    .rst            (rst),
    .divisor_valid  (divisor_valid),
    .divisor_ready  (divisor_ready),
    .divisor        (divisor),
    .start          (start),
    .busy           (busy),
    .dividend       (dividend),
    .done           (done),
    .quotient       (quotient),
    .divide_by_zero (divide_by_zero)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watch both input channels and the result strobe at each rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (done)
        quot_board.check_quotient(quotient, divide_by_zero);
      if (divisor_valid && divisor_ready)
        quot_board.load_divisor(divisor);
      if (start && !busy)
        quot_board.note_dividend(dividend);
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offer one dividend beat, idling at random first, and wait until taken
  task automatic send_dividend(logic [IO_WIDTH-1:0] x);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      start    <= 1'b0;
      dividend <= $urandom;
      @(negedge clk);
    end
    start    <= 1'b1;
    dividend <= x;
    do @(posedge clk); while (busy);
  endtask

  // Drain the pipeline, then write a new divisor
  task automatic write_divisor(logic [IO_WIDTH-1:0] d);
    @(negedge clk);
    start <= 1'b0;
    while (quot_board.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    divisor_valid <= 1'b1;
    divisor       <= d;
    do @(posedge clk); while (!divisor_ready);
    @(negedge clk);
    divisor_valid <= 1'b0;
  endtask

  function automatic logic [IO_WIDTH-1:0] pick_divisor();
    logic [IO_WIDTH-1:0] mag;
    case ($urandom_range(9))
      0, 1, 2: mag = $urandom_range(20, 1);
      3:       mag = 32'd1 << $urandom_range(31);
      4: begin
        case ($urandom_range(5))
          0:       return 32'h0000_0000;
          1:       return 32'h0000_0001;
          2:       return 32'hffff_ffff;
          3:       return 32'h8000_0000;
          4:       return 32'h7fff_ffff;
          default: return 32'h8000_0001;
        endcase
      end
      5, 6:    mag = $urandom >> $urandom_range(31);
      default: return $urandom;
    endcase
    return $urandom_range(1) ? -mag : mag;
  endfunction

  // Mix full-range values with quotient boundaries of the current divisor
  function automatic logic [IO_WIDTH-1:0] pick_dividend(logic [IO_WIDTH-1:0] d);
    int q;
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom;
      4:          return $urandom_range(2000) - 1000;
      5: begin
        case ($urandom_range(4))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 32'h0000_0000;
          3:       return 32'hffff_ffff;
          default: return 32'h8000_0001;
        endcase
      end
      6, 7: begin
        q = $signed($urandom) >>> $urandom_range(31);
        return q * $signed(d) + ($urandom_range(2) - 1);
      end
      default: begin
        q = $signed($urandom) >>> $urandom_range(31);
        return q;
      end
    endcase
  endfunction

  // Run random divisor segments until about the given number of beats
  task automatic run_segments(int unsigned target);
    int unsigned         sent;
    int unsigned         n;
    logic [IO_WIDTH-1:0] d;
    sent = 0;
    while (sent < target) begin
      d = pick_divisor();
      write_divisor(d);
      n = $urandom_range(30, 5);
      repeat (n) send_dividend(pick_dividend(d));
      sent += n;
    end
  endtask

  initial begin
    logic [IO_WIDTH-1:0] at_one[$];
    logic [IO_WIDTH-1:0] at_minus[$];
    logic [IO_WIDTH-1:0] at_zero[$];
    logic [IO_WIDTH-1:0] at_minint[$];
    logic [IO_WIDTH-1:0] at_seven[$];
    at_one          = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff,
                        32'h8000_0000, 32'h5555_5555, 32'haaaa_aaaa,
                        32'd12345};
    at_minus        = '{32'h8000_0000, 32'h1, 32'hffff_ffff,
                        32'h7fff_ffff, 32'h0};
    at_zero         = '{32'h7fff_ffff, 32'h8000_0000, 32'd5};
    at_minint       = '{32'h8000_0000, 32'h8000_0001,
                        32'hffff_ffff, 32'h0};
    at_seven        = '{32'hffff_fff9, 32'd7, 32'hffff_fffa,
                        32'h8000_0000, 32'h7fff_ffff};
    start           = 1'b0;
    dividend        = '0;
    divisor_valid   = 1'b0;
    divisor         = '0;
    rst             = 1'b1;
    cycle_count     = 0;
    sender_idle_pct = 16;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // directed: reset divisor, then minus one, zero, most negative and seven
    foreach (at_one[i]) send_dividend(at_one[i]);
    write_divisor(32'hffff_ffff);
    foreach (at_minus[i]) send_dividend(at_minus[i]);
    write_divisor(32'h0);
    foreach (at_zero[i]) send_dividend(at_zero[i]);
    write_divisor(32'h8000_0000);
    foreach (at_minint[i]) send_dividend(at_minint[i]);
    write_divisor(32'd7);
    foreach (at_seven[i]) send_dividend(at_seven[i]);

    // random: three idle rates on the dividend side
    run_segments(292);
    sender_idle_pct = 57;
    run_segments(317);
    sender_idle_pct = 0;
    run_segments(316);

    // drain the last beats and allow for stray results
    @(negedge clk);
    start <= 1'b0;
    while (quot_board.pending() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    if (quot_board.errors == 0 && quot_board.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
